// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each assumes clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RSC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define RSC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== src/rsc_pkg.sv =====
`timescale 1ns / 1ps
package rsc_pkg;

	localparam int RES_DEF = 16;
	localparam int COMP_W  = 17;
	localparam int ONE_Q16 = 65536;
	localparam int WORD_W  = 32;
	localparam int IDX_W   = 16;
	// shared divide / square-root unit widths
	localparam int DIV_W   = 40;
	localparam int DEN_W   = 24;
	localparam int OPD_W   = 48;
	localparam int ROOT_W  = 24;

	localparam logic [1:0] REQ_LOAD_COEF  = 2'd0;
	localparam logic [1:0] REQ_LOAD_SCALE = 2'd1;
	localparam logic [1:0] REQ_CONVERT    = 2'd2;

	typedef struct packed {
		logic start;
		logic is_sqrt;
	} du_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} du_stat_t;

endpackage

// ===== src/rsc_divsqrt.sv =====
`timescale 1ns / 1ps
// Radix-2 restoring divider / digit-by-digit integer square root.
// Divide: 40-bit dividend in opd_a[39:0], 24-bit divisor, 40 steps.
// Sqrt: 48-bit operand, 24-bit floor root, 24 steps.
module rsc_divsqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rsc_pkg::du_req_t              req,
	input  logic [rsc_pkg::OPD_W-1:0]     opd_a,
	input  logic [rsc_pkg::DEN_W-1:0]     opd_b,
	output rsc_pkg::du_stat_t             stat,
	output logic [rsc_pkg::DIV_W-1:0]     result
);

	logic                          busy_q, done_q, sqrt_q;
	logic [5:0]                    cnt_q;
	logic [26:0]                   rem_q, rem_n, rem_t, trial;
	logic [rsc_pkg::OPD_W-1:0]     acc_q;
	logic [rsc_pkg::DIV_W-1:0]     quo_q;
	logic [rsc_pkg::DEN_W-1:0]     den_q;
	logic                          fit;

	// one step of the selected recurrence
	always_comb begin
		if (sqrt_q) begin
			rem_t = {rem_q[24:0], acc_q[rsc_pkg::OPD_W-1 -: 2]};
			trial = {1'b0, quo_q[rsc_pkg::ROOT_W-1:0], 2'b01};
		end else begin
			rem_t = {2'b00, rem_q[23:0], acc_q[rsc_pkg::OPD_W-1]};
			trial = {3'b000, den_q};
		end
		fit   = (rem_t >= trial);
		rem_n = fit ? (rem_t - trial) : rem_t;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.is_sqrt ? 6'(rsc_pkg::ROOT_W - 1) : 6'(rsc_pkg::DIV_W - 1);
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			sqrt_q <= req.is_sqrt;
			acc_q  <= req.is_sqrt ? opd_a : {opd_a[rsc_pkg::DIV_W-1:0], 8'd0};
			den_q  <= opd_b;
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= {quo_q[rsc_pkg::DIV_W-2:0], fit};
			acc_q <= sqrt_q ? {acc_q[rsc_pkg::OPD_W-3:0], 2'b00}
				: {acc_q[rsc_pkg::OPD_W-2:0], 1'b0};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign result    = quo_q;

endmodule

// ===== src/rgb_to_sigmoid_coefficients_top.sv =====
`timescale 1ns / 1ps
// RGB to sigmoid-polynomial coefficient lookup.
// Input channel (in_valid / in_ready): one word per request. Load-coefficient and
// load-scale words are written in the cycle they are accepted and give no result;
// type 3 is dropped. A convert word gives exactly one result word on the output
// channel (out_valid / out_ready) carrying coeff_a, coeff_b, coeff_c.
// in_ready is high only while the sequencer is idle; one convert is processed at
// a time through one shared divide / square-root unit and one coefficient-memory
// read port.
// Work per convert: grey triples take a 24-step root then a 40-step divide; pure
// black or white go straight to the result; other triples take 40-step divides
// for x and y, a binary search of the scale table, a 40-step divide for z when the
// scale interval is non-empty and z lies above its lower end, then per coefficient
// eight corner reads and 7 interpolation steps.
// A finished result sits in the output register; if the receiver stalls, the
// sequencer holds the next result until the register frees, and loads keep
// being accepted meanwhile once the sequencer is idle.
// Reset returns the sequencer to idle and clears out_valid; the tables are not
// cleared and must be loaded before use.
module rgb_to_sigmoid_coefficients_top #(
	parameter int RES = rsc_pkg::RES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       req_type,
	input  logic [rsc_pkg::IDX_W-1:0]        table_index,
	input  logic signed [rsc_pkg::WORD_W-1:0] table_value,
	input  logic [rsc_pkg::COMP_W-1:0]       red,
	input  logic [rsc_pkg::COMP_W-1:0]       green,
	input  logic [rsc_pkg::COMP_W-1:0]       blue,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [rsc_pkg::WORD_W-1:0] coeff_a,
	output logic signed [rsc_pkg::WORD_W-1:0] coeff_b,
	output logic signed [rsc_pkg::WORD_W-1:0] coeff_c
);

	`include "assert_macros.svh"

	localparam int RW         = $clog2(RES);
	localparam int SW         = RW + 1;
	localparam int COEF_WORDS = 9 * RES * RES * RES;
	localparam int AW         = $clog2(COEF_WORDS);
	localparam int QW         = 16 + RW;
	localparam int DX         = 3;
	localparam int DY         = 3 * RES;
	localparam int DZ         = 3 * RES * RES;
	localparam int CW         = rsc_pkg::COMP_W;
	localparam int WW         = rsc_pkg::WORD_W;

	typedef enum logic [4:0] {
		S_IDLE, S_GPREP, S_GSQRT, S_GDIV, S_XDIV, S_YDIV, S_COORD, S_BS, S_BSCMP,
		S_ZRD0, S_ZRD1, S_DEN, S_ZDIV, S_ADDR, S_RD, S_LA, S_LB, S_DONE
	} state_t;

	state_t                       state_q;
	logic                         go_q, sqrt_sel_q;
	logic [rsc_pkg::OPD_W-1:0]    du_a_q;
	logic [rsc_pkg::DEN_W-1:0]    du_b_q;
	rsc_pkg::du_req_t             du_req;
	rsc_pkg::du_stat_t            du_stat;
	logic [rsc_pkg::DIV_W-1:0]    du_res;

	logic [CW-1:0]                z_q, cx_q, cy_q, v_q, s0_q;
	logic [1:0]                   sel_q;
	logic [QW-1:0]                xq_q, yq_q;
	logic [RW-1:0]                xi_q, yi_q, zi_q;
	logic [CW-1:0]                x1_q, y1_q, z1_q;
	logic [SW-1:0]                first_q, size_q, mid_q;
	logic [AW-1:0]                base_q;
	logic [1:0]                   j_q;
	logic [3:0]                   rd_cnt_q, len_q;
	logic [2:0]                   op_q;
	logic signed [WW-1:0]         wq_q [8];
	logic signed [WW-1:0]         cf_q [3];
	logic signed [WW-1:0]         a_q;
	logic signed [50:0]           prod_q;
	logic                         out_valid_q;
	logic signed [WW-1:0]         out_a_q, out_b_q, out_c_q;

	// coefficient and scale memories
	logic signed [WW-1:0]         coef_mem [COEF_WORDS];
	logic [CW-1:0]                scale_mem [RES];
	logic signed [WW-1:0]         mem_rd_q;
	logic [CW-1:0]                sc_rd_q;
	logic [AW-1:0]                coef_addr, corner_off;
	logic [RW-1:0]                sc_addr;
	logic                         coef_we, scale_we, accept;

	// input decode
	logic [CW-1:0]                cr, cg, cb, cz, ccx, ccy;
	logic [1:0]                   csel;
	logic                         grey;
	logic [SW-1:0]                half, mid_nx;
	logic [RW-1:0]                xi_nx, yi_nx;
	logic [33:0]                  gprod;
	logic [14:0]                  absnum;
	logic                         gneg;
	logic [CW-1:0]                wsel;
	logic signed [51:0]           lerp_sum;
	logic signed [WW-1:0]         lerp_res;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign coef_we  = accept && (req_type == rsc_pkg::REQ_LOAD_COEF)
		&& (32'(table_index) < 32'(COEF_WORDS));
	assign scale_we = accept && (req_type == rsc_pkg::REQ_LOAD_SCALE)
		&& (32'(table_index) < 32'(RES));

	// saturate components, pick the largest (later index wins ties)
	always_comb begin
		cr = (red   > CW'(rsc_pkg::ONE_Q16)) ? CW'(rsc_pkg::ONE_Q16) : red;
		cg = (green > CW'(rsc_pkg::ONE_Q16)) ? CW'(rsc_pkg::ONE_Q16) : green;
		cb = (blue  > CW'(rsc_pkg::ONE_Q16)) ? CW'(rsc_pkg::ONE_Q16) : blue;
		grey = (cr == cg) && (cg == cb);
		csel = 2'd0;
		cz   = cr;
		if (cg >= cz) begin
			csel = 2'd1;
			cz   = cg;
		end
		if (cb >= cz) begin
			csel = 2'd2;
			cz   = cb;
		end
		case (csel)
			2'd0: begin
				ccx = cg;
				ccy = cb;
			end
			2'd1: begin
				ccx = cb;
				ccy = cr;
			end
			default: begin
				ccx = cr;
				ccy = cg;
			end
		endcase
	end

	// grey path operands
	always_comb begin
		gprod  = 34'(v_q) * 34'(CW'(rsc_pkg::ONE_Q16) - v_q);
		gneg   = (v_q < CW'(rsc_pkg::ONE_Q16 / 2));
		absnum = gneg ? 15'(CW'(rsc_pkg::ONE_Q16 / 2) - v_q)
			: 15'(v_q - CW'(rsc_pkg::ONE_Q16 / 2));
	end

	// coordinates and search step
	always_comb begin
		xi_nx  = (xq_q[QW-1:16] > RW'(RES - 2)) ? RW'(RES - 2) : xq_q[QW-1:16];
		yi_nx  = (yq_q[QW-1:16] > RW'(RES - 2)) ? RW'(RES - 2) : yq_q[QW-1:16];
		half   = size_q >> 1;
		mid_nx = first_q + half;
	end

	// corner offset within the 2x2x2 neighborhood
	always_comb begin
		corner_off = (rd_cnt_q[0] ? AW'(DX) : AW'(0))
			+ (rd_cnt_q[1] ? AW'(DY) : AW'(0))
			+ (rd_cnt_q[2] ? AW'(DZ) : AW'(0));
		coef_addr  = (state_q == S_IDLE) ? AW'(table_index)
			: (base_q + AW'(j_q) + corner_off);
		case (state_q)
			S_BS:    sc_addr = mid_nx[RW-1:0];
			S_ZRD1:  sc_addr = zi_q + RW'(1);
			default: sc_addr = zi_q;
		endcase
	end

	// interpolation weight and result
	always_comb begin
		if (op_q < 3'd4) begin
			wsel = x1_q;
		end else if (op_q < 3'd6) begin
			wsel = y1_q;
		end else begin
			wsel = z1_q;
		end
		lerp_sum = 52'(a_q) + 52'(prod_q >>> 16);
		lerp_res = lerp_sum[WW-1:0];
	end

	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[coef_addr] <= table_value;
		end
		mem_rd_q <= coef_mem[coef_addr];
	end

	always_ff @(posedge clk) begin
		if (scale_we) begin
			scale_mem[table_index[RW-1:0]] <= table_value[CW-1:0];
		end
		sc_rd_q <= scale_mem[sc_addr];
	end

	assign du_req.start   = go_q;
	assign du_req.is_sqrt = sqrt_sel_q;

	rsc_divsqrt u_divsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (du_req),
		.opd_a  (du_a_q),
		.opd_b  (du_b_q),
		.stat   (du_stat),
		.result (du_res)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			go_q        <= 1'b0;
			sqrt_sel_q  <= 1'b0;
			out_valid_q <= 1'b0;
			du_a_q      <= '0;
			du_b_q      <= '0;
			z_q <= '0; cx_q <= '0; cy_q <= '0; v_q <= '0; s0_q <= '0;
			sel_q <= '0; xq_q <= '0; yq_q <= '0;
			xi_q <= '0; yi_q <= '0; zi_q <= '0;
			x1_q <= '0; y1_q <= '0; z1_q <= '0;
			first_q <= '0; size_q <= '0; mid_q <= '0;
			base_q <= '0; j_q <= '0; rd_cnt_q <= '0; len_q <= '0; op_q <= '0;
			a_q <= '0; prod_q <= '0;
			out_a_q <= '0; out_b_q <= '0; out_c_q <= '0;
			for (int i = 0; i < 8; i++) wq_q[i] <= '0;
			for (int i = 0; i < 3; i++) cf_q[i] <= '0;
		end else begin
			go_q <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && (req_type == rsc_pkg::REQ_CONVERT)) begin
						z_q   <= cz;
						cx_q  <= ccx;
						cy_q  <= ccy;
						sel_q <= csel;
						v_q   <= cr;
						cf_q[0] <= '0;
						cf_q[1] <= '0;
						if (grey && (cr == '0)) begin
							cf_q[2] <= {1'b1, {(WW-1){1'b0}}};
							state_q <= S_DONE;
						end else if (grey && (cr == CW'(rsc_pkg::ONE_Q16))) begin
							cf_q[2] <= {1'b0, {(WW-1){1'b1}}};
							state_q <= S_DONE;
						end else if (grey) begin
							state_q <= S_GPREP;
						end else begin
							du_a_q     <= rsc_pkg::OPD_W'((40'(ccx) * 40'(RES - 1)) << 16);
							du_b_q     <= rsc_pkg::DEN_W'(cz);
							sqrt_sel_q <= 1'b0;
							go_q       <= 1'b1;
							state_q    <= S_XDIV;
						end
					end
				end
				S_GPREP: begin
					du_a_q     <= {gprod[31:0], 16'd0};
					sqrt_sel_q <= 1'b1;
					go_q       <= 1'b1;
					state_q    <= S_GSQRT;
				end
				S_GSQRT: begin
					if (du_stat.done) begin
						du_a_q     <= rsc_pkg::OPD_W'({absnum, 24'd0});
						du_b_q     <= du_res[rsc_pkg::DEN_W-1:0];
						sqrt_sel_q <= 1'b0;
						go_q       <= 1'b1;
						state_q    <= S_GDIV;
					end
				end
				S_GDIV: begin
					if (du_stat.done) begin
						if (!gneg) begin
							cf_q[2] <= (du_res > 40'h007FFFFFFF) ? {1'b0, {(WW-1){1'b1}}}
								: du_res[WW-1:0];
						end else begin
							cf_q[2] <= (du_res > 40'h0080000000) ? {1'b1, {(WW-1){1'b0}}}
								: WW'(-du_res[WW-1:0]);
						end
						state_q <= S_DONE;
					end
				end
				S_XDIV: begin
					if (du_stat.done) begin
						xq_q    <= du_res[QW-1:0];
						du_a_q  <= rsc_pkg::OPD_W'((40'(cy_q) * 40'(RES - 1)) << 16);
						go_q    <= 1'b1;
						state_q <= S_YDIV;
					end
				end
				S_YDIV: begin
					if (du_stat.done) begin
						yq_q    <= du_res[QW-1:0];
						state_q <= S_COORD;
					end
				end
				S_COORD: begin
					xi_q    <= xi_nx;
					yi_q    <= yi_nx;
					x1_q    <= CW'(xq_q - {xi_nx, 16'd0});
					y1_q    <= CW'(yq_q - {yi_nx, 16'd0});
					first_q <= SW'(1);
					size_q  <= SW'(RES - 2);
					state_q <= S_BS;
				end
				S_BS: begin
					if (size_q == '0) begin
						zi_q    <= RW'(first_q - SW'(1));
						state_q <= S_ZRD0;
					end else begin
						mid_q   <= mid_nx;
						state_q <= S_BSCMP;
					end
				end
				S_BSCMP: begin
					if (sc_rd_q < z_q) begin
						first_q <= mid_q + SW'(1);
						size_q  <= size_q - half - SW'(1);
					end else begin
						size_q <= half;
					end
					state_q <= S_BS;
				end
				S_ZRD0: begin
					state_q <= S_ZRD1;
				end
				S_ZRD1: begin
					s0_q    <= sc_rd_q;
					state_q <= S_DEN;
				end
				S_DEN: begin
					if ((sc_rd_q > s0_q) && (z_q > s0_q)) begin
						du_a_q     <= rsc_pkg::OPD_W'({z_q - s0_q, 16'd0});
						du_b_q     <= rsc_pkg::DEN_W'(sc_rd_q - s0_q);
						sqrt_sel_q <= 1'b0;
						go_q       <= 1'b1;
						state_q    <= S_ZDIV;
					end else begin
						z1_q    <= '0;
						state_q <= S_ADDR;
					end
				end
				S_ZDIV: begin
					if (du_stat.done) begin
						z1_q    <= (du_res > 40'(rsc_pkg::ONE_Q16)) ? CW'(rsc_pkg::ONE_Q16)
							: du_res[CW-1:0];
						state_q <= S_ADDR;
					end
				end
				S_ADDR: begin
					base_q   <= AW'((((int'(sel_q) * RES + int'(zi_q)) * RES + int'(yi_q))
						* RES + int'(xi_q)) * 3);
					j_q      <= '0;
					rd_cnt_q <= '0;
					state_q  <= S_RD;
				end
				S_RD: begin
					if (rd_cnt_q != 4'd0) begin
						wq_q[3'(rd_cnt_q - 4'd1)] <= mem_rd_q;
					end
					if (rd_cnt_q == 4'd8) begin
						len_q   <= 4'd8;
						op_q    <= '0;
						state_q <= S_LA;
					end else begin
						rd_cnt_q <= rd_cnt_q + 4'd1;
					end
				end
				S_LA: begin
					prod_q  <= (33'(wq_q[1]) - 33'(wq_q[0])) * $signed({1'b0, wsel});
					a_q     <= wq_q[0];
					state_q <= S_LB;
				end
				S_LB: begin
					// pop two operands, push the blend at the queue tail
					for (int i = 0; i < 6; i++) wq_q[i] <= wq_q[i + 2];
					wq_q[3'(len_q - 4'd2)] <= lerp_res;
					len_q <= len_q - 4'd1;
					if (op_q == 3'd6) begin
						cf_q[j_q] <= lerp_res;
						if (j_q == 2'd2) begin
							state_q <= S_DONE;
						end else begin
							j_q      <= j_q + 2'd1;
							rd_cnt_q <= '0;
							state_q  <= S_RD;
						end
					end else begin
						op_q    <= op_q + 3'd1;
						state_q <= S_LA;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_a_q     <= cf_q[0];
						out_b_q     <= cf_q[1];
						out_c_q     <= cf_q[2];
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign coeff_a   = out_a_q;
	assign coeff_b   = out_b_q;
	assign coeff_c   = out_c_q;

	`RSC_ASSERT_IMPL(a_lerp_last, (state_q == S_LB) && (op_q == 3'd6), len_q == 4'd2)
	`RSC_ASSERT_IMPL(a_bs_range, state_q == S_BSCMP, (mid_q >= SW'(1)) && (mid_q <= SW'(RES - 2)))
	`RSC_ASSERT_IMPL(a_du_free, du_req.start, !du_stat.busy)
	`RSC_ASSERT_NEXT(a_du_runs, du_req.start, du_stat.busy)

endmodule
